>>> hdl/arp_rl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARP receive and learn - shared definitions
// Field codes, status codes and register indexes used across the block.
// ----------------------------------------------------------------------------
package arp_rl_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;
    localparam logic [15:0] OP_REPLY    = 16'h0002;

    localparam logic [1:0] ST_NOT_OURS    = 2'd0;
    localparam logic [1:0] ST_REPLIED     = 2'd1;
    localparam logic [1:0] ST_OURS_NO_REP = 2'd2;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int ENTRY_W = IP_W + MAC_W;

endpackage : arp_rl_pkg
`default_nettype wire

>>> hdl/arp_rl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module arp_rl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule : arp_rl_ram
`default_nettype wire

>>> hdl/arp_receive_and_learn.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARP receive and learn
// Checks one received ARP packet, learns the sender and builds reply fields.
// ----------------------------------------------------------------------------
// One packet is handled at a time. An unsupported packet (not Ethernet/IPv4)
// gives its result straight after the check state, with no table scan. Otherwise
// the address table is scanned through the RAM read port, one entry per cycle,
// stopping at the first match, and at most the learnt entries are read. The
// result is then held until taken, and the next packet is accepted in the
// cycle after that. Entries are filled in order and never removed, so a
// fill count marks which entries are valid; no clearing after reset is needed.
// ----------------------------------------------------------------------------
module arp_receive_and_learn
    import arp_rl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [47:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] hw_type,
    input  wire logic [15:0] proto_type,
    input  wire logic [15:0] arp_op,
    input  wire logic [47:0] sender_mac,
    input  wire logic [31:0] sender_ip,
    input  wire logic [31:0] target_ip,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic             table_dropped,
    output logic [47:0]      reply_target_mac,
    output logic [31:0]      reply_target_ip,
    output logic [47:0]      reply_sender_mac,
    output logic [31:0]      reply_sender_ip,
    output logic [15:0]      reply_code
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_OUT
    } state_t;

    state_t          state_reg;
    logic [31:0]     own_ip_reg;
    logic [47:0]     own_mac_reg;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   idx_reg;
    logic [AW-1:0]   last_addr_reg;
    logic            pend_reg;

    // latched item
    logic [15:0]     hw_reg;
    logic [15:0]     proto_reg;
    logic [15:0]     op_reg;
    logic [47:0]     smac_reg;
    logic [31:0]     sip_reg;
    logic [31:0]     tip_reg;

    logic [ENTRY_W-1:0] rd_data;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic               hit;
    logic               scan_done;
    logic               for_us;
    logic               is_request;
    logic               full;

    assign in_ready   = (state_reg == S_IDLE);
    assign hit        = pend_reg && (rd_data[IP_W-1:0] == sip_reg);
    assign scan_done  = hit || (idx_reg == fill_reg);
    assign for_us     = (tip_reg == own_ip_reg);
    assign is_request = (op_reg == OP_REQUEST);
    assign full       = (fill_reg == FULL_COUNT);

    // refresh on a hit, otherwise add at the first free slot when addressed to us and not full
    assign ram_we    = (state_reg == S_SEARCH) && scan_done
                       && (hit || (for_us && !full));
    assign ram_waddr = hit ? last_addr_reg : fill_reg[AW-1:0];

    arp_rl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data ({smac_reg, sip_reg}),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hw_reg    <= hw_type;
            proto_reg <= proto_type;
            op_reg    <= arp_op;
            smac_reg  <= sender_mac;
            sip_reg   <= sender_ip;
            tip_reg   <= target_ip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            own_ip_reg       <= '0;
            own_mac_reg      <= '0;
            fill_reg         <= '0;
            idx_reg          <= '0;
            last_addr_reg    <= '0;
            pend_reg         <= 1'b0;
            out_valid        <= 1'b0;
            status           <= ST_NOT_OURS;
            table_dropped    <= 1'b0;
            reply_target_mac <= '0;
            reply_target_ip  <= '0;
            reply_sender_mac <= '0;
            reply_sender_ip  <= '0;
            reply_code       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_OWN_IP:  own_ip_reg  <= cfg_data[31:0];
                    REG_OWN_MAC: own_mac_reg <= cfg_data;
                    default:     ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        idx_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    if (hw_reg != HW_ETHERNET || proto_reg != PROTO_IPV4)
                    begin
                        status           <= ST_UNSUPPORTED;
                        table_dropped    <= 1'b0;
                        reply_target_mac <= '0;
                        reply_target_ip  <= '0;
                        reply_sender_mac <= '0;
                        reply_sender_ip  <= '0;
                        reply_code       <= '0;
                        out_valid        <= 1'b1;
                        state_reg        <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SEARCH;
                    end
                end

                S_SEARCH:
                begin
                    if (scan_done)
                    begin
                        if (!hit && for_us && !full)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        table_dropped <= !hit && for_us && full;
                        if (!for_us)
                        begin
                            status <= ST_NOT_OURS;
                        end
                        else if (is_request)
                        begin
                            status <= ST_REPLIED;
                        end
                        else
                        begin
                            status <= ST_OURS_NO_REP;
                        end
                        if (for_us && is_request)
                        begin
                            reply_target_mac <= smac_reg;
                            reply_target_ip  <= sip_reg;
                            reply_sender_mac <= own_mac_reg;
                            reply_sender_ip  <= own_ip_reg;
                            reply_code       <= OP_REPLY;
                        end
                        else
                        begin
                            reply_target_mac <= '0;
                            reply_target_ip  <= '0;
                            reply_sender_mac <= '0;
                            reply_sender_ip  <= '0;
                            reply_code       <= '0;
                        end
                        pend_reg  <= 1'b0;
                        out_valid <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        // read for idx_reg is issued this cycle, compared next
                        last_addr_reg <= idx_reg[AW-1:0];
                        idx_reg       <= idx_reg + 1'b1;
                        pend_reg      <= 1'b1;
                    end
                end

                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule : arp_receive_and_learn
`default_nettype wire
